// ===== rtl/alas_pkg.sv =====
// Shared constants and types for the array list append, remove and search unit.
package alas_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_SEARCH = 2'd2
    } func_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

// ===== rtl/alas_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module alas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/array_list_append_remove_search_unit.sv =====
// Top level of the bounded array list with append, remove and search operations.
//
// One item is taken when start is high and busy is low, and its result appears on the
// result ports for one cycle with done high; the receiver cannot stall it. The unit takes
// no new item before it is through with the last one. A successful remove moves every
// later entry down one place per cycle through the list memory, which has one read
// port and one write port. A search reads and compares the memory one entry per cycle
// from index 0 until it hits or has read every entry. The result reports the count
// after the operation.
module array_list_append_remove_search_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [alas_pkg::FUNC_W-1:0]         func,
    input  logic signed [alas_pkg::DATA_W-1:0]  value,
    input  logic [alas_pkg::POS_W-1:0]          position,
    output logic                                done,
    output logic                                success,
    output logic [alas_pkg::IDX_W-1:0]          found_position,
    output logic [alas_pkg::CNT_W-1:0]          count,
    output logic                                empty_res,
    output logic                                full_res
);

    import alas_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               ok_reg, ok_next;
    logic [IDX_W-1:0]   found_reg, found_next;
    func_t              func_reg;
    logic [DATA_W-1:0]  value_reg;
    logic [POS_W-1:0]   pos_reg;

    logic               done_reg;
    logic               success_reg;
    logic [IDX_W-1:0]   found_pos_reg;
    logic [CNT_W-1:0]   count_out_reg;
    logic               empty_reg;
    logic               full_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    alas_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        ok_next     = ok_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = rd_idx_reg - IDX_W'(1);
        mem_wdata   = value_reg;
        mem_raddr   = rd_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ok_next    = 1'b0;
                found_next = '0;
                state_next = S_DONE;
                case (func_reg)
                    FUNC_APPEND:
                    begin
                        if (count_reg < CNT_W'(CAPACITY))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (CNT_W'(pos_reg) < count_reg)
                        begin
                            if (CNT_W'(pos_reg) + CNT_W'(1) < count_reg)
                            begin
                                rd_idx_next = IDX_W'(pos_reg) + IDX_W'(1);
                                mem_raddr   = IDX_W'(pos_reg) + IDX_W'(1);
                                state_next  = S_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                    end
                    FUNC_SEARCH:
                    begin
                        if (count_reg != '0)
                        begin
                            rd_idx_next = '0;
                            mem_raddr   = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_idx_reg - IDX_W'(1);
                mem_wdata = mem_rdata;
                if (CNT_W'(rd_idx_reg) + CNT_W'(1) < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                    mem_raddr   = rd_idx_reg + IDX_W'(1);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (mem_rdata == value_reg)
                begin
                    ok_next    = 1'b1;
                    found_next = rd_idx_reg;
                    state_next = S_DONE;
                end
                else if (CNT_W'(rd_idx_reg) + CNT_W'(1) < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                    mem_raddr   = rd_idx_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            done_reg   <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        found_reg <= found_next;
        if (state_reg == S_IDLE && start)
        begin
            func_reg  <= func_t'(func);
            value_reg <= value;
            pos_reg   <= position;
        end
        if (state_reg == S_DONE)
        begin
            success_reg   <= ok_reg;
            found_pos_reg <= found_reg;
            count_out_reg <= count_reg;
            empty_reg     <= (count_reg == '0);
            full_reg      <= (count_reg == CNT_W'(CAPACITY));
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign success        = success_reg;
    assign found_position = found_pos_reg;
    assign count          = count_out_reg;
    assign empty_res      = empty_reg;
    assign full_res       = full_reg;

endmodule

// ===== rtl/alas_check.sv =====
// Port-level checker for the array list unit and the bind that attaches it.
module alas_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic                                success,
    input  logic [alas_pkg::IDX_W-1:0]          found_position,
    input  logic [alas_pkg::CNT_W-1:0]          count,
    input  logic                                empty_res,
    input  logic                                full_res
);

    import alas_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("An accepted item did not make the unit busy.");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("A result was shown while the unit was still busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (empty_res == (count == '0)) && (full_res == (count == CNT_W'(CAPACITY))))
        else $error("The empty or full flag disagrees with the count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !success) |-> (found_position == '0))
        else $error("A failed item reported a non-zero position.");

endmodule

bind array_list_append_remove_search_unit alas_check u_alas_check (.*);

// ===== test/list_result_checker.sv =====
// Checker that predicts and compares every result of the array list unit.
module list_result_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [alas_pkg::FUNC_W-1:0]         func,
    input  logic signed [alas_pkg::DATA_W-1:0]  value,
    input  logic [alas_pkg::POS_W-1:0]          position,
    input  logic                                done,
    input  logic                                success,
    input  logic [alas_pkg::IDX_W-1:0]          found_position,
    input  logic [alas_pkg::CNT_W-1:0]          count,
    input  logic                                empty_res,
    input  logic                                full_res,
    output int                                  fail_count,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import alas_pkg::*;

    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] found;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } list_result_t;

    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int                       shadow_len = 0;
    int                       errors     = 0;
    list_result_t             awaited_results [$];

    function automatic list_result_t apply_list_op(
        input logic [FUNC_W-1:0]        op,
        input logic signed [DATA_W-1:0] val,
        input logic [POS_W-1:0]         pos
    );
        list_result_t res;
        int           i;
        res = '0;
        case (op)
            FUNC_APPEND:
            begin
                if (shadow_len < CAPACITY)
                begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                    res.success = 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (int'(pos) < shadow_len)
                begin
                    for (i = int'(pos); i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                    res.success = 1'b1;
                end
            end
            FUNC_SEARCH:
            begin
                for (i = 0; i < shadow_len; i++)
                begin
                    if (shadow_list[i] == val)
                    begin
                        res.success = 1'b1;
                        res.found   = IDX_W'(i);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count = CNT_W'(shadow_len);
        res.empty = (shadow_len == 0);
        res.full  = (shadow_len == CAPACITY);
        return res;
    endfunction

    function automatic int field_differs(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            awaited_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no item waiting: expected none, actual count %0d",
                             $time, count);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    errors += field_differs("success", want.success, success);
                    errors += field_differs("found_position", want.found, found_position);
                    errors += field_differs("count", want.count, count);
                    errors += field_differs("empty_res", want.empty, empty_res);
                    errors += field_differs("full_res", want.full, full_res);
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_list_op(func, value, position));
        end
        fail_count  <= errors;
        outstanding <= awaited_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the testbench: clock, reset, item stimulus and the final verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alas_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int MODE_FILL    = 0;
    localparam int MODE_DRAIN   = 1;
    localparam int MODE_MIX     = 2;
    localparam int RANDOM_ITEMS = 430;
    localparam int QUIET_TAIL   = 60;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     start    = 1'b0;
    logic [FUNC_W-1:0]        func     = '0;
    logic signed [DATA_W-1:0] value    = '0;
    logic [POS_W-1:0]         position = '0;
    logic                     busy;
    logic                     done;
    logic                     success;
    logic [IDX_W-1:0]         found_position;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;
    logic                     full_res;
    int                       fail_count;
    int                       outstanding;

    logic signed [DATA_W-1:0] appended_vals [64];
    int                       appended_n   = 0;
    int                       last_count   = 0;
    bit                       idle_allowed = 1'b1;

    array_list_append_remove_search_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .value          (value),
        .position       (position),
        .done           (done),
        .success        (success),
        .found_position (found_position),
        .count          (count),
        .empty_res      (empty_res),
        .full_res       (full_res)
    );

    list_result_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .value          (value),
        .position       (position),
        .done           (done),
        .success        (success),
        .found_position (found_position),
        .count          (count),
        .empty_res      (empty_res),
        .full_res       (full_res),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (done)
            last_count <= int'(count);
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                             input logic [POS_W-1:0] p);
        int gap;
        gap = 0;
        if (idle_allowed && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        func     <= f;
        value    <= v;
        position <= p;
        if (f == FUNC_APPEND)
        begin
            appended_vals[appended_n % 64] = v;
            appended_n++;
        end
        do @(posedge clk); while (busy);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5:    return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item(input int mode);
        int                       r;
        int                       t_app;
        int                       t_rem;
        int                       t_srch;
        logic [FUNC_W-1:0]        f;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         p;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                t_app = 75; t_rem = 85; t_srch = 95;
            end
            MODE_DRAIN:
            begin
                t_app = 12; t_rem = 80; t_srch = 95;
            end
            default:
            begin
                t_app = 35; t_rem = 65; t_srch = 95;
            end
        endcase
        f = (r < t_app) ? FUNC_APPEND : (r < t_rem) ? FUNC_REMOVE :
            (r < t_srch) ? FUNC_SEARCH : FUNC_UNUSED;
        if (f == FUNC_SEARCH && appended_n > 0 && $urandom_range(0, 9) < 7)
            v = appended_vals[$urandom_range(0, ((appended_n < 64) ? appended_n : 64) - 1)];
        else
            v = pick_value();
        if (last_count > 0 && $urandom_range(0, 4) != 0)
            p = POS_W'($urandom_range(0, last_count - 1));
        else
            p = POS_W'($urandom_range(0, 63));
        send_item(f, v, p);
    endtask

    initial
    begin
        int item_no;
        int seg;
        int mode;
        int len;
        item_no = 0;
        seg     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(FUNC_SEARCH, 32'sd5, 6'd0);
        send_item(FUNC_REMOVE, 32'sd0, 6'd0);
        send_item(FUNC_UNUSED, -32'sd1, 6'd63);
        send_item(FUNC_APPEND, 32'sh8000_0000, 6'd0);
        send_item(FUNC_APPEND, 32'sh7fff_ffff, 6'd0);
        send_item(FUNC_APPEND, 32'sd0, 6'd0);
        send_item(FUNC_APPEND, -32'sd1, 6'd0);
        send_item(FUNC_APPEND, 32'sh7fff_ffff, 6'd0);
        send_item(FUNC_SEARCH, 32'sh7fff_ffff, 6'd63);
        send_item(FUNC_SEARCH, 32'sh8000_0000, 6'd0);
        send_item(FUNC_SEARCH, -32'sd1, 6'd0);
        send_item(FUNC_SEARCH, 32'sd12345, 6'd0);
        send_item(FUNC_REMOVE, 32'sd0, 6'd63);
        send_item(FUNC_REMOVE, 32'sd0, 6'd5);
        send_item(FUNC_REMOVE, 32'sd0, 6'd4);
        send_item(FUNC_REMOVE, 32'sd0, 6'd0);
        send_item(FUNC_REMOVE, 32'sd0, 6'd1);
        send_item(FUNC_UNUSED, 32'sh7fff_ffff, 6'h2a);
        send_item(FUNC_SEARCH, 32'sd0, 6'd0);

        while (item_no < RANDOM_ITEMS)
        begin
            mode = (seg == 0) ? MODE_FILL : (seg == 1) ? MODE_DRAIN : $urandom_range(0, 2);
            len  = (seg == 0) ? 90 : (seg == 1) ? 110 : $urandom_range(20, 60);
            for (int k = 0; k < len && item_no < RANDOM_ITEMS; k++)
            begin
                idle_allowed = (item_no < RANDOM_ITEMS - QUIET_TAIL);
                random_item(mode);
                item_no++;
            end
            seg++;
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
